// ===== design/lrt_pkg.sv =====
// Shared types, codes and constants for the route table.
package lrt_pkg;

	localparam int DEF_TABLE_ENTRIES = 32;
	localparam int PORT_COUNT = 16;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOROUTE = 2'd1;
	localparam logic [1:0] ST_CONFLICT = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_BADPORT = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] address;
		logic [31:0] net_mask;
		logic [31:0] gateway;
		logic [3:0] port_id;
		logic direct_route;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	typedef struct packed {
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] hop;
		logic [3:0] port;
		logic direct;
	} slot_t;

endpackage

// ===== design/lrt_front.sv =====
// Command intake: classifies each word and holds it in a two-entry queue.
module lrt_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic opcode,
	input logic [31:0] address,
	input logic [31:0] net_mask,
	input logic [31:0] gateway,
	input logic [3:0] port_id,
	input logic direct_route,
	output lrt_pkg::q_head_t head,
	input logic pop
);
	import lrt_pkg::*;

	localparam int QDEPTH = 2;

	cmd_t ent_q [QDEPTH];
	logic [1:0] cnt_q;
	cmd_t new_cmd;
	logic push;
	logic wr_sel;

	always_comb begin
		new_cmd.address = address;
		new_cmd.net_mask = net_mask;
		new_cmd.gateway = gateway;
		new_cmd.port_id = port_id;
		new_cmd.direct_route = direct_route;
		if (opcode == OP_INSERT) begin
			new_cmd.kind = (32'(port_id) >= PORT_COUNT) ? KIND_BADPORT : KIND_INSERT;
		end else begin
			new_cmd.kind = KIND_LOOKUP;
		end
	end

	assign busy = (cnt_q == 2'(QDEPTH));
	assign push = start && !busy;
	assign wr_sel = (cnt_q != 2'd0) && !pop;
	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd = ent_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !wr_sel) begin
			ent_q[0] <= new_cmd;
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
		end
		if (push && wr_sel) begin
			ent_q[1] <= new_cmd;
		end
	end

endmodule

// ===== design/lrt_back.sv =====
// Execution engine: scans the route memory for lookups and inserts.
module lrt_back #(
	parameter int TABLE_ENTRIES = lrt_pkg::DEF_TABLE_ENTRIES
) (
	input logic clk,
	input logic arst_n,
	input lrt_pkg::q_head_t head,
	output logic pop,
	output logic done,
	output logic [1:0] status,
	output logic [3:0] out_port,
	output logic [31:0] out_hop
);
	import lrt_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	slot_t mem_q [TABLE_ENTRIES];
	slot_t rd_data_s1;
	logic rd_vld_s1;

	logic [1:0] state_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] scan_q;
	logic found_q;
	logic conflict_q;
	logic done_q;
	cmd_t cmd_q;
	logic [31:0] best_mask_q;
	logic [31:0] best_hop_q;
	logic [3:0] best_port_q;
	logic best_direct_q;

	logic hit;
	logic better;
	logic same;
	logic full;
	logic do_write;
	logic [CNT_W-1:0] scan_next;
	slot_t wr_slot;

	assign pop = (state_q == S_IDLE) && head.valid;
	assign hit = (((cmd_q.address ^ rd_data_s1.dest) & rd_data_s1.mask) == 32'd0);
	assign better = hit && (!found_q || (rd_data_s1.mask > best_mask_q));
	assign same = (rd_data_s1.port == cmd_q.port_id) && (rd_data_s1.dest == cmd_q.address)
		&& (rd_data_s1.mask == cmd_q.net_mask);
	assign full = (fill_q >= CNT_W'(TABLE_ENTRIES));
	assign do_write = (state_q == S_FINISH) && (cmd_q.kind == KIND_INSERT) && !conflict_q
		&& !full;
	assign scan_next = scan_q + CNT_W'(1);
	assign done = done_q;

	always_comb begin
		wr_slot.dest = cmd_q.address;
		wr_slot.mask = cmd_q.net_mask;
		wr_slot.hop = cmd_q.direct_route ? 32'd0 : cmd_q.gateway;
		wr_slot.port = cmd_q.port_id;
		wr_slot.direct = cmd_q.direct_route;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			scan_q <= '0;
			found_q <= 1'b0;
			conflict_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
			done_q <= (state_q == S_FINISH);
			if (rd_vld_s1) begin
				if (cmd_q.kind == KIND_LOOKUP && better) begin
					found_q <= 1'b1;
				end
				if (cmd_q.kind == KIND_INSERT && same) begin
					conflict_q <= 1'b1;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						scan_q <= '0;
						found_q <= 1'b0;
						conflict_q <= 1'b0;
						if (fill_q == '0 || head.cmd.kind == KIND_BADPORT) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					scan_q <= scan_next;
					if (scan_next == fill_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (do_write) begin
						fill_q <= fill_q + CNT_W'(1);
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && head.valid) begin
			cmd_q <= head.cmd;
		end
		if (rd_vld_s1 && better) begin
			best_mask_q <= rd_data_s1.mask;
			best_hop_q <= rd_data_s1.hop;
			best_port_q <= rd_data_s1.port;
			best_direct_q <= rd_data_s1.direct;
		end
		if (state_q == S_FINISH) begin
			status <= ST_NOROUTE;
			out_port <= 4'd0;
			out_hop <= 32'd0;
			case (cmd_q.kind)
				KIND_LOOKUP: begin
					if (found_q) begin
						status <= ST_OK;
						out_port <= best_port_q;
						out_hop <= best_direct_q ? cmd_q.address : best_hop_q;
					end
				end
				KIND_INSERT: begin
					if (conflict_q) begin
						status <= ST_CONFLICT;
					end else if (full) begin
						status <= ST_FULL;
					end else begin
						status <= ST_OK;
					end
				end
				default: begin
					status <= ST_NOROUTE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			rd_data_s1 <= mem_q[scan_q[IDX_W-1:0]];
		end
		if (do_write) begin
			mem_q[fill_q[IDX_W-1:0]] <= wr_slot;
		end
	end

endmodule

// ===== design/lpm_route_table.sv =====
// Route table top level: longest-prefix-match lookup and route insert.
// A word passes through scan, drain and finish before done; an empty table or a bad port
// skips the scan and drain. The back end reads the route memory one entry per cycle and
// finishes one word before it takes the next; the front queue takes up to two more words meanwhile.
// Reset empties the table and the queue; done, once raised, lasts one cycle.
module lpm_route_table #(
	parameter int TABLE_ENTRIES = lrt_pkg::DEF_TABLE_ENTRIES
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic opcode,
	input logic [31:0] address,
	input logic [31:0] net_mask,
	input logic [31:0] gateway,
	input logic [3:0] port_id,
	input logic direct_route,
	output logic done,
	output logic [1:0] status,
	output logic [3:0] out_port,
	output logic [31:0] out_hop
);
	import lrt_pkg::*;

	q_head_t head;
	logic pop;

	lrt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.address(address),
		.net_mask(net_mask),
		.gateway(gateway),
		.port_id(port_id),
		.direct_route(direct_route),
		.head(head),
		.pop(pop)
	);

	lrt_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.done(done),
		.status(status),
		.out_port(out_port),
		.out_hop(out_hop)
	);

endmodule

// ===== design/lrt_checker.sv =====
// Port-level checks for the route table, bound to its top level.
module lrt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [1:0] status,
	input logic [3:0] out_port,
	input logic [31:0] out_hop
);
	import lrt_pkg::*;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result strobe held for more than one cycle.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (out_port == 4'd0 && out_hop == 32'd0))
		else $error("Refused or unmatched word carries a nonzero device or hop.");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("Busy rose without an accepted word.");

endmodule

bind lpm_route_table lrt_checker u_lrt_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the longest-prefix-match route table.
`timescale 1ns / 100ps

module tb_top;
	import lrt_pkg::*;

	localparam int NUM_SLOTS = DEF_TABLE_ENTRIES;
	localparam int NUM_DIRECTED = 22;
	localparam int NUM_RANDOM = 750;
	localparam int QUIET_TAIL = 120;
	localparam int DRAIN_CYCLES = NUM_SLOTS + 8;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] port;
		logic [31:0] hop;
	} answer_t;

	typedef struct packed {
		logic op;
		logic [31:0] addr;
		logic [31:0] mask;
		logic [31:0] gw;
		logic [3:0] port;
		logic direct;
		logic typed;
		answer_t ans;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic opcode;
	logic [31:0] address;
	logic [31:0] net_mask;
	logic [31:0] gateway;
	logic [3:0] port_id;
	logic direct_route;
	logic done;
	logic [1:0] status;
	logic [3:0] out_port;
	logic [31:0] out_hop;

	logic route_valid [NUM_SLOTS];
	logic [31:0] route_dest [NUM_SLOTS];
	logic [31:0] route_mask [NUM_SLOTS];
	logic [31:0] route_hop [NUM_SLOTS];
	logic [3:0] route_port [NUM_SLOTS];
	logic route_direct [NUM_SLOTS];
	int route_count = 0;

	answer_t pending_answers [$];
	answer_t head_ans;
	dir_row_t dir_rows [NUM_DIRECTED];
	int err_count = 0;
	int cycle_count = 0;

	lpm_route_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.address(address),
		.net_mask(net_mask),
		.gateway(gateway),
		.port_id(port_id),
		.direct_route(direct_route),
		.done(done),
		.status(status),
		.out_port(out_port),
		.out_hop(out_hop)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_answers.size());
			$display("[lpm_route_table] ERROR");
			$finish;
		end
	end

	function automatic answer_t predict_route(input logic op, input logic [31:0] addr,
			input logic [31:0] mask, input logic [31:0] gw, input logic [3:0] port,
			input logic direct);
		answer_t ans;
		logic found;
		int best;
		ans = '{status: ST_OK, port: 4'd0, hop: 32'd0};
		found = 1'b0;
		best = 0;
		if (op == OP_INSERT) begin
			if (port >= PORT_COUNT) begin
				ans.status = ST_NOROUTE;
				return ans;
			end
			for (int k = 0; k < NUM_SLOTS; k++) begin
				if (route_valid[k] && route_port[k] == port && route_dest[k] == addr &&
						route_mask[k] == mask)
					found = 1'b1;
			end
			if (found)
				ans.status = ST_CONFLICT;
			else if (route_count >= NUM_SLOTS)
				ans.status = ST_FULL;
			else begin
				route_valid[route_count] = 1'b1;
				route_dest[route_count] = addr;
				route_mask[route_count] = mask;
				route_hop[route_count] = direct ? 32'd0 : gw;
				route_port[route_count] = port;
				route_direct[route_count] = direct;
				route_count++;
			end
			return ans;
		end
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (route_valid[k] && (addr & route_mask[k]) == (route_dest[k] & route_mask[k]))
				if (!found || route_mask[k] > route_mask[best]) begin
					found = 1'b1;
					best = k;
				end
		end
		if (!found)
			ans.status = ST_NOROUTE;
		else begin
			ans.port = route_port[best];
			ans.hop = route_direct[best] ? addr : route_hop[best];
		end
		return ans;
	endfunction

	task automatic send_word(input logic op, input logic [31:0] addr, input logic [31:0] mask,
			input logic [31:0] gw, input logic [3:0] port, input logic direct,
			input logic typed, input answer_t typed_ans);
		answer_t predicted;
		start = 1'b1;
		opcode = op;
		address = addr;
		net_mask = mask;
		gateway = gw;
		port_id = port;
		direct_route = direct;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = predict_route(op, addr, mask, gw, port, direct);
		pending_answers.insert(pending_answers.size(), typed ? typed_ans : predicted);
		@(negedge clk);
	endtask

	task automatic idle_gap(input int cycles);
		start = 1'b0;
		repeat (cycles)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual status=%0d port=%0d hop=%h",
					$time, status, out_port, out_hop);
				err_count++;
			end else begin
				head_ans = pending_answers.pop_front();
				if (status !== head_ans.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, head_ans.status, status);
					err_count++;
				end
				if (out_port !== head_ans.port) begin
					$display("%0t: out_port mismatch: expected %0d, actual %0d",
						$time, head_ans.port, out_port);
					err_count++;
				end
				if (out_hop !== head_ans.hop) begin
					$display("%0t: out_hop mismatch: expected %h, actual %h",
						$time, head_ans.hop, out_hop);
					err_count++;
				end
			end
		end
	end

	initial begin
		logic [31:0] pool [4];
		logic [31:0] r_addr;
		logic [31:0] r_mask;
		logic [31:0] r_gw;
		logic [3:0] r_port;
		logic r_direct;
		logic r_op;
		logic idle_ok;
		int plen;
		int k;

		for (int i = 0; i < NUM_SLOTS; i++) begin
			route_valid[i] = 1'b0;
			route_dest[i] = 32'd0;
			route_mask[i] = 32'd0;
			route_hop[i] = 32'd0;
			route_port[i] = 4'd0;
			route_direct[i] = 1'b0;
		end
		for (int i = 0; i < 4; i++)
			pool[i] = $urandom;

		dir_rows = '{
			'{OP_LOOKUP, 32'h00000000, 32'h0, 32'h0, 4'd0, 1'b0, 1'b1, '{ST_NOROUTE, 4'd0, 32'h0}},
			'{OP_LOOKUP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'd15, 1'b1, 1'b1,
				'{ST_NOROUTE, 4'd0, 32'h0}},
			'{OP_INSERT, 32'h00000000, 32'h00000000, 32'h0A000001, 4'd0, 1'b0, 1'b1,
				'{ST_OK, 4'd0, 32'h0}},
			'{OP_INSERT, 32'h00000000, 32'h00000000, 32'h0A000002, 4'd0, 1'b0, 1'b1,
				'{ST_CONFLICT, 4'd0, 32'h0}},
			'{OP_INSERT, 32'h00000000, 32'h00000000, 32'hFFFFFFFF, 4'd15, 1'b0, 1'b1,
				'{ST_OK, 4'd0, 32'h0}},
			'{OP_LOOKUP, 32'h12345678, 32'h0, 32'h0, 4'd0, 1'b0, 1'b0, '0},
			'{OP_INSERT, 32'hC0A80000, 32'hFFFF0000, 32'hC0A80001, 4'd3, 1'b0, 1'b1,
				'{ST_OK, 4'd0, 32'h0}},
			'{OP_INSERT, 32'hC0A80100, 32'hFFFFFF00, 32'hFFFFFFFF, 4'd5, 1'b1, 1'b1,
				'{ST_OK, 4'd0, 32'h0}},
			'{OP_LOOKUP, 32'hC0A801FF, 32'h0, 32'h0, 4'd0, 1'b0, 1'b0, '0},
			'{OP_LOOKUP, 32'hC0A8FF01, 32'h0, 32'h0, 4'd0, 1'b0, 1'b0, '0},
			'{OP_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h12345678, 4'd9, 1'b0, 1'b1,
				'{ST_OK, 4'd0, 32'h0}},
			'{OP_LOOKUP, 32'hFFFFFFFF, 32'h0, 32'h0, 4'd0, 1'b0, 1'b0, '0},
			'{OP_INSERT, 32'h00000000, 32'hFFFFFFFF, 32'h00000000, 4'd1, 1'b1, 1'b1,
				'{ST_OK, 4'd0, 32'h0}},
			'{OP_LOOKUP, 32'h00000000, 32'h0, 32'h0, 4'd0, 1'b0, 1'b0, '0},
			'{OP_INSERT, 32'hA5A5A5A5, 32'hF0F0F0F0, 32'h5A5A5A5A, 4'd7, 1'b0, 1'b1,
				'{ST_OK, 4'd0, 32'h0}},
			'{OP_LOOKUP, 32'hA0A0A0A0, 32'h0, 32'h0, 4'd0, 1'b0, 1'b0, '0},
			'{OP_INSERT, 32'hC0A80000, 32'hFFFF0000, 32'h0B0B0B0B, 4'd4, 1'b0, 1'b1,
				'{ST_OK, 4'd0, 32'h0}},
			'{OP_LOOKUP, 32'hC0A80505, 32'h0, 32'h0, 4'd0, 1'b0, 1'b0, '0},
			'{OP_INSERT, 32'hC0A801FF, 32'hFFFFFF00, 32'h01020304, 4'd5, 1'b0, 1'b1,
				'{ST_OK, 4'd0, 32'h0}},
			'{OP_LOOKUP, 32'hC0A80142, 32'h0, 32'h0, 4'd0, 1'b0, 1'b0, '0},
			'{OP_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 4'd9, 1'b1, 1'b1,
				'{ST_CONFLICT, 4'd0, 32'h0}},
			'{OP_LOOKUP, 32'h7FFFFFFF, 32'h0, 32'h0, 4'd0, 1'b0, 1'b0, '0}
		};

		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_LOOKUP;
		address = 32'd0;
		net_mask = 32'd0;
		gateway = 32'd0;
		port_id = 4'd0;
		direct_route = 1'b0;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			send_word(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].mask, dir_rows[i].gw,
				dir_rows[i].port, dir_rows[i].direct, dir_rows[i].typed, dir_rows[i].ans);
			if ($urandom_range(0, 3) == 0)
				idle_gap($urandom_range(1, 10));
		end

		idle_ok = 1'b1;
		for (int i = 0; i < NUM_RANDOM; i++) begin
			r_op = ($urandom_range(0, 99) < 12) ? OP_INSERT : OP_LOOKUP;
			r_gw = $urandom;
			r_port = 4'($urandom_range(0, 15));
			r_direct = 1'($urandom_range(0, 1));
			if (r_op == OP_INSERT && route_count > 0 && $urandom_range(0, 3) == 0) begin
				// Reuse the key of a stored route so that the conflict check is hit.
				k = $urandom_range(0, route_count - 1);
				r_addr = route_dest[k];
				r_mask = route_mask[k];
				r_port = route_port[k];
			end else if (r_op == OP_INSERT) begin
				plen = $urandom_range(0, 32);
				r_mask = (plen == 0) ? 32'd0 : (32'hFFFFFFFF << (32 - plen));
				if ($urandom_range(0, 6) == 0)
					r_mask = $urandom;
				r_addr = $urandom;
				if ($urandom_range(0, 9) < 7)
					r_addr = (pool[$urandom_range(0, 3)] & 32'hFFFF0000) |
						(r_addr & 32'h0000FFFF);
			end else begin
				r_mask = $urandom;
				r_addr = $urandom;
				if (route_count > 0 && $urandom_range(0, 9) < 6) begin
					k = $urandom_range(0, route_count - 1);
					r_addr = (route_dest[k] & route_mask[k]) | (r_addr & ~route_mask[k]);
				end else if ($urandom_range(0, 1) == 0)
					r_addr = (pool[$urandom_range(0, 3)] & 32'hFFFF0000) |
						(r_addr & 32'h0000FFFF);
			end
			send_word(r_op, r_addr, r_mask, r_gw, r_port, r_direct, 1'b0, '0);
			if (i % 40 == 0)
				idle_ok = $urandom_range(0, 2) != 0;
			if (i < NUM_RANDOM - QUIET_TAIL && idle_ok && $urandom_range(0, 2) == 0)
				idle_gap($urandom_range(1, 10));
		end

		start = 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (err_count == 0)
			$display("[lpm_route_table] OK");
		else
			$display("[lpm_route_table] ERROR");
		$finish;
	end

endmodule
